// ===== rtl/ftbm_pkg.sv =====
`timescale 1ns / 1ps
package ftbm_pkg;

    localparam int TRAP_SLOTS_DEF = 64;
    localparam int COORD_BITS_DEF = 16;
    localparam int MAX_VISITS_DEF = 16;

    localparam int SLOT_W  = 6;
    localparam int FIELD_W = 16;
    localparam int HW_W    = 15;
    localparam int CNT_W   = 7;
    localparam int VPOS_W  = 4;

    localparam int CFG_ADDR_W = 3;
    localparam logic [CFG_ADDR_W-1:0] REG_HALF_WIDTH = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_TRAP_COUNT = 3'd4;

    localparam logic [HW_W-1:0]  HALF_WIDTH_RST = 15'd256;
    localparam logic [CNT_W-1:0] TRAP_COUNT_RST = 7'd64;

    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_VISIT = 1'b1;

    typedef struct packed {
        logic load_wr;
        logic visit_start;
        logic scan;
        logic finish;
    } t_dp_cmd;

    typedef struct packed {
        logic skip;
        logic hit;
        logic scan_end;
        logic last;
        logic out_block;
    } t_dp_sts;

endpackage

// ===== rtl/ftbm_ram.sv =====
`timescale 1ns / 1ps
module ftbm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/ftbm_ctrl.sv =====
`timescale 1ns / 1ps
module ftbm_ctrl
    import ftbm_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  logic    i_mode,
    output logic    o_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_DONE = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_ready = (r_state == ST_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    if (i_mode == MODE_LOAD) begin
                        o_cmd.load_wr = 1'b1;
                    end else begin
                        o_cmd.visit_start = 1'b1;
                        n_state = i_sts.skip ? ST_DONE : ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.hit || i_sts.scan_end) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                // a result beat cannot overwrite one still waiting
                if (!(i_sts.last && i_sts.out_block)) begin
                    o_cmd.finish = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    a_finish_only_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |=> (r_state == ST_IDLE))
        else $error("finish did not return to idle");

    a_scan_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN && (i_sts.hit || i_sts.scan_end)) |=> (r_state == ST_DONE))
        else $error("scan did not stop on hit or end");

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.scan || o_cmd.finish) |-> !(o_cmd.load_wr || o_cmd.visit_start))
        else $error("input taken while busy");

endmodule

// ===== rtl/ftbm_dp.sv =====
`timescale 1ns / 1ps
module ftbm_dp
    import ftbm_pkg::*;
#(
    parameter int TRAP_SLOTS = TRAP_SLOTS_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int MAX_VISITS = MAX_VISITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_dp_cmd            i_cmd,
    output t_dp_sts            o_sts,
    input  logic [SLOT_W-1:0]  i_slot,
    input  logic [FIELD_W-1:0] i_x,
    input  logic [FIELD_W-1:0] i_y,
    input  logic               i_last,
    input  logic [HW_W-1:0]    i_half_width,
    input  logic [CNT_W-1:0]   i_trap_count,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    output logic               o_caught,
    output logic [SLOT_W-1:0]  o_trap_index,
    output logic [VPOS_W-1:0]  o_visit_index
);

    localparam int AW = (TRAP_SLOTS > 1) ? $clog2(TRAP_SLOTS) : 1;
    localparam int CW = $clog2(TRAP_SLOTS + 1);
    localparam int C  = COORD_BITS;
    localparam int DW = (C + 1 > HW_W) ? C + 1 : HW_W;
    localparam logic [8:0] SLOTS9 = 9'(TRAP_SLOTS);
    localparam logic [VPOS_W-1:0] POS_TOP =
        VPOS_W'((MAX_VISITS - 1 > 15) ? 15 : MAX_VISITS - 1);

    logic signed [C-1:0] w_x;
    logic signed [C-1:0] w_y;

    generate
        if (C <= FIELD_W) begin : g_narrow
            assign w_x = i_x[C-1:0];
            assign w_y = i_y[C-1:0];
        end else begin : g_wide
            // wider coordinates see the 16-bit field as non-negative
            assign w_x = C'(i_x);
            assign w_y = C'(i_y);
        end
    endgenerate

    logic signed [C-1:0] r_vx;
    logic signed [C-1:0] r_vy;
    logic                r_last;
    logic [CW-1:0]       r_rd_idx;
    logic [CW-1:0]       r_cmp_idx;
    logic                r_cmp_vld;
    logic                r_caught_flag;
    logic [SLOT_W-1:0]   r_caught_trap;
    logic [VPOS_W-1:0]   r_caught_visit;
    logic [VPOS_W-1:0]   r_visit_pos;
    logic                r_out_vld;
    logic                r_out_caught;
    logic [SLOT_W-1:0]   r_out_trap;
    logic [VPOS_W-1:0]   r_out_visit;

    // table size in use
    logic [8:0]    w_cnt9;
    logic [CW-1:0] w_n;
    logic [CW-1:0] w_n_m1;
    assign w_cnt9 = 9'(i_trap_count);
    assign w_n    = (w_cnt9 > SLOTS9) ? CW'(SLOTS9) : CW'(w_cnt9);
    assign w_n_m1 = CW'(w_n - 1'b1);

    // slot decode for loads
    logic [8:0] w_slot9;
    logic       w_slot_ok;
    assign w_slot9   = 9'(i_slot);
    assign w_slot_ok = (w_slot9 < SLOTS9);

    logic [2*C-1:0] w_rdata;

    ftbm_ram #(
        .WIDTH (2 * C),
        .DEPTH (TRAP_SLOTS),
        .AW    (AW)
    ) u_trap_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.load_wr && w_slot_ok),
        .i_waddr (w_slot9[AW-1:0]),
        .i_wdata ({w_y, w_x}),
        .i_raddr (r_rd_idx[AW-1:0]),
        .o_rdata (w_rdata)
    );

    // box test against the trap read last cycle
    logic signed [C-1:0] w_tx;
    logic signed [C-1:0] w_ty;
    logic signed [C:0]   w_dx;
    logic signed [C:0]   w_dy;
    logic [C:0]          w_adx;
    logic [C:0]          w_ady;
    logic                w_match;

    assign w_tx  = w_rdata[C-1:0];
    assign w_ty  = w_rdata[2*C-1:C];
    assign w_dx  = {w_tx[C-1], w_tx} - {r_vx[C-1], r_vx};
    assign w_dy  = {w_ty[C-1], w_ty} - {r_vy[C-1], r_vy};
    assign w_adx = w_dx[C] ? (C+1)'(-w_dx) : w_dx;
    assign w_ady = w_dy[C] ? (C+1)'(-w_dy) : w_dy;
    assign w_match = (DW'(w_adx) <= DW'(i_half_width)) &&
                     (DW'(w_ady) <= DW'(i_half_width));

    logic [8:0] w_cmp9;
    assign w_cmp9 = 9'(r_cmp_idx);

    always_comb begin
        o_sts.skip      = r_caught_flag || (w_n == '0);
        o_sts.hit       = r_cmp_vld && w_match;
        o_sts.scan_end  = r_cmp_vld && (r_cmp_idx == w_n_m1);
        o_sts.last      = r_last;
        o_sts.out_block = r_out_vld && !i_out_ready;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.visit_start) begin
            r_vx   <= w_x;
            r_vy   <= w_y;
            r_last <= i_last;
        end
        if (i_cmd.visit_start) begin
            r_rd_idx <= '0;
        end else if (i_cmd.scan && (r_rd_idx < w_n_m1)) begin
            r_rd_idx <= r_rd_idx + 1'b1;
        end
        r_cmp_idx <= r_rd_idx;
        if (i_cmd.finish && r_last) begin
            r_out_caught <= r_caught_flag;
            r_out_trap   <= r_caught_trap;
            r_out_visit  <= r_caught_visit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmp_vld      <= 1'b0;
            r_caught_flag  <= 1'b0;
            r_caught_trap  <= '0;
            r_caught_visit <= '0;
            r_visit_pos    <= '0;
            r_out_vld      <= 1'b0;
        end else begin
            r_cmp_vld <= i_cmd.scan && !(o_sts.hit || o_sts.scan_end);
            if (i_cmd.scan && o_sts.hit) begin
                r_caught_flag  <= 1'b1;
                r_caught_trap  <= w_cmp9[SLOT_W-1:0];
                r_caught_visit <= r_visit_pos;
            end
            if (i_cmd.finish) begin
                if (r_last) begin
                    r_caught_flag  <= 1'b0;
                    r_caught_trap  <= '0;
                    r_caught_visit <= '0;
                    r_visit_pos    <= '0;
                end else if (r_visit_pos < POS_TOP) begin
                    r_visit_pos <= r_visit_pos + 1'b1;
                end
            end
            if (i_cmd.finish && r_last) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_out_valid   = r_out_vld;
    assign o_caught      = r_out_caught;
    assign o_trap_index  = r_out_trap;
    assign o_visit_index = r_out_visit;

    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.finish && r_last) |=> r_out_vld)
        else $error("group end gave no result beat");

    a_clear_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_caught_flag |-> (r_caught_trap == '0 && r_caught_visit == '0))
        else $error("stale catch data without catch flag");

    a_read_in_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.scan |-> (r_rd_idx < w_n))
        else $error("scan read past trap count");

    a_pos_saturates: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_visit_pos <= POS_TOP)
        else $error("visit position past its top");

endmodule

// ===== rtl/first_trap_box_match.sv =====
`timescale 1ns / 1ps
// Channel      Dir  Beat contents (low bit first)
// s_axis       in   tdata: trap_slot, x_coord, y_coord; tuser: mode; tlast: last_visit
// m_axis       out  tdata: caught, trap_index, visit_index
// APB          in   0x0 catch_half_width, 0x4 trap_count
//
// A load beat writes its slot with no scan. A visit beat scans traps from slot 0
// and stops at the first hit, or after n traps when none hits (n = trap_count
// capped at TRAP_SLOTS); it skips the scan when the group is already caught or
// trap_count is zero. The single read port of the trap RAM scans one trap a cycle.
// Reset is synchronous and active low; trap RAM contents are kept, undefined
// until loaded. A waiting result beat stalls only the next group-end visit.
module first_trap_box_match
    import ftbm_pkg::*;
#(
    parameter int TRAP_SLOTS = TRAP_SLOTS_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int MAX_VISITS = MAX_VISITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [39:0]           s_axis_tdata,  // trap_slot, x_coord, y_coord, pad
    input  logic                  s_axis_tuser,  // mode
    input  logic                  s_axis_tlast,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [15:0]           m_axis_tdata,  // caught, trap_index, visit_index, pad
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    logic [HW_W-1:0]  r_half_width;
    logic [CNT_W-1:0] r_trap_count;
    logic [CFG_ADDR_W-1:0] w_reg_addr;

    assign pready     = 1'b1;
    assign w_reg_addr = {paddr[CFG_ADDR_W-1:2], 2'b00};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_width <= HALF_WIDTH_RST;
            r_trap_count <= TRAP_COUNT_RST;
        end else if (psel && penable && pwrite && pready) begin
            case (w_reg_addr)
                REG_HALF_WIDTH: r_half_width <= pwdata[HW_W-1:0];
                REG_TRAP_COUNT: r_trap_count <= pwdata[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_reg_addr)
            REG_HALF_WIDTH: prdata = 32'(r_half_width);
            REG_TRAP_COUNT: prdata = 32'(r_trap_count);
            default:        prdata = '0;
        endcase
    end

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    logic              w_caught;
    logic [SLOT_W-1:0] w_trap_index;
    logic [VPOS_W-1:0] w_visit_index;

    ftbm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .i_mode  (s_axis_tuser),
        .o_ready (s_axis_tready),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    ftbm_dp #(
        .TRAP_SLOTS (TRAP_SLOTS),
        .COORD_BITS (COORD_BITS),
        .MAX_VISITS (MAX_VISITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_slot        (s_axis_tdata[5:0]),
        .i_x           (s_axis_tdata[21:6]),
        .i_y           (s_axis_tdata[37:22]),
        .i_last        (s_axis_tlast),
        .i_half_width  (r_half_width),
        .i_trap_count  (r_trap_count),
        .i_out_ready   (m_axis_tready),
        .o_out_valid   (m_axis_tvalid),
        .o_caught      (w_caught),
        .o_trap_index  (w_trap_index),
        .o_visit_index (w_visit_index)
    );

    assign m_axis_tdata = {5'b0, w_visit_index, w_trap_index, w_caught};

endmodule

// ===== sim/tb_first_trap_box_match.sv =====
`timescale 1ns / 1ps
module tb_first_trap_box_match;
    import ftbm_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int SETTLE      = 100;
    localparam int PHASES      = 8;
    localparam int PHASE_BEATS = 250;
    localparam int POS_TOP     = (MAX_VISITS_DEF - 1 > 15) ? 15 : MAX_VISITS_DEF - 1;

    typedef struct packed {
        logic              caught;
        logic [SLOT_W-1:0] trap;
        logic [VPOS_W-1:0] visit;
    } t_verdict;

    typedef struct packed {
        logic                  is_cfg;
        logic                  mode;
        logic [SLOT_W-1:0]     slot;
        logic [FIELD_W-1:0]    x;
        logic [FIELD_W-1:0]    y;
        logic                  last;
        logic                  pinned;
        t_verdict              want;
        logic [CFG_ADDR_W-1:0] addr;
        logic [31:0]           value;
    } t_plan_row;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    wire                   s_axis_tready;
    logic [39:0]           s_axis_tdata  = '0;   // trap_slot, x_coord, y_coord, pad
    logic                  s_axis_tuser  = 1'b0; // mode
    logic                  s_axis_tlast  = 1'b0; // last_visit
    wire                   m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    wire  [15:0]           m_axis_tdata;         // caught, trap_index, visit_index, pad
    logic                  psel          = 1'b0;
    logic                  penable       = 1'b0;
    logic                  pwrite        = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr         = '0;
    logic [31:0]           pwdata        = '0;
    wire  [31:0]           prdata;
    wire                   pready;

    first_trap_box_match dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #2 i_clk = ~i_clk;

    // trap table and group state as the block should hold them
    logic signed [FIELD_W-1:0] trap_x [TRAP_SLOTS_DEF];
    logic signed [FIELD_W-1:0] trap_y [TRAP_SLOTS_DEF];
    logic [HW_W-1:0]           half_width = HALF_WIDTH_RST;
    logic [CNT_W-1:0]          trap_count = TRAP_COUNT_RST;
    logic                      grp_caught = 1'b0;
    logic [SLOT_W-1:0]         grp_trap   = '0;
    logic [VPOS_W-1:0]         grp_visit  = '0;
    logic [VPOS_W-1:0]         grp_pos    = '0;

    t_verdict expected_verdicts[$];

    int   errors      = 0;
    int   cycle_count = 0;
    int   n_results   = 0;
    int   n_loads     = 0;
    int   n_visits    = 0;
    int   n_groups    = 0;
    int   n_caught    = 0;
    int   n_long      = 0;
    int   n_settings  = 0;
    int   rx_wait     = 0;
    logic tx_steady   = 1'b0;
    logic rx_steady   = 1'b0;

    function automatic void flag_error(input string msg);
        errors++;
        if (errors <= 10) $display("%s", msg);
    endfunction

    function automatic logic step_traps(input logic mode, input logic [SLOT_W-1:0] slot,
                                        input logic signed [FIELD_W-1:0] x,
                                        input logic signed [FIELD_W-1:0] y,
                                        input logic last, output t_verdict res);
        int n;
        int dx;
        int dy;
        res = '0;
        if (mode == MODE_LOAD) begin
            trap_x[slot] = x;
            trap_y[slot] = y;
            return 1'b0;
        end
        n = (trap_count > TRAP_SLOTS_DEF) ? TRAP_SLOTS_DEF : int'(trap_count);
        // once caught, the rest of the group is not tested
        for (int j = 0; j < n && !grp_caught; j++) begin
            dx = int'(trap_x[j]) - int'(x);
            dy = int'(trap_y[j]) - int'(y);
            if (dx < 0) dx = -dx;
            if (dy < 0) dy = -dy;
            if (dx <= int'(half_width) && dy <= int'(half_width)) begin
                grp_caught = 1'b1;
                grp_trap   = SLOT_W'(j);
                grp_visit  = grp_pos;
            end
        end
        if (grp_pos < POS_TOP) grp_pos++;
        if (!last) return 1'b0;
        res = '{grp_caught, grp_trap, grp_visit};
        if (grp_pos == POS_TOP) n_long++;
        grp_caught = 1'b0;
        grp_trap   = '0;
        grp_visit  = '0;
        grp_pos    = '0;
        return 1'b1;
    endfunction

    function automatic int near_offset();
        int hw;
        hw = int'(half_width);
        case ($urandom_range(0, 4))
            0:       return hw;
            1:       return -hw;
            2:       return hw + 1;
            3:       return -hw - 1;
            default: return int'($urandom_range(0, 2 * hw)) - hw;
        endcase
    endfunction

    function automatic t_plan_row load_row(input logic [SLOT_W-1:0] slot,
                                           input logic [FIELD_W-1:0] x,
                                           input logic [FIELD_W-1:0] y, input logic last);
        t_plan_row r;
        r      = '0;
        r.mode = MODE_LOAD;
        r.slot = slot;
        r.x    = x;
        r.y    = y;
        r.last = last;
        return r;
    endfunction

    function automatic t_plan_row visit_row(input logic [FIELD_W-1:0] x,
                                            input logic [FIELD_W-1:0] y, input logic last);
        t_plan_row r;
        r      = '0;
        r.mode = MODE_VISIT;
        r.x    = x;
        r.y    = y;
        r.last = last;
        return r;
    endfunction

    // group-closing visit with the result written out by hand
    function automatic t_plan_row caught_row(input logic [FIELD_W-1:0] x,
                                             input logic [FIELD_W-1:0] y, input logic caught,
                                             input logic [SLOT_W-1:0] trap,
                                             input logic [VPOS_W-1:0] visit);
        t_plan_row r;
        r        = visit_row(x, y, 1'b1);
        r.pinned = 1'b1;
        r.want   = '{caught, trap, visit};
        return r;
    endfunction

    function automatic t_plan_row cfg_row(input logic [CFG_ADDR_W-1:0] addr,
                                          input logic [31:0] value);
        t_plan_row r;
        r        = '0;
        r.is_cfg = 1'b1;
        r.addr   = addr;
        r.value  = value;
        return r;
    endfunction

    task automatic send_beat(input logic mode, input logic [SLOT_W-1:0] slot,
                             input logic [FIELD_W-1:0] x, input logic [FIELD_W-1:0] y,
                             input logic last, input logic pinned, input t_verdict want);
        int       gap;
        t_verdict res;
        gap = tx_steady ? 0 : $urandom_range(0, 9);
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, y, x, slot};
        s_axis_tuser  <= mode;
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        if (mode == MODE_LOAD) n_loads++;
        else n_visits++;
        if (step_traps(mode, slot, x, y, last, res)) begin
            expected_verdicts.push_back(pinned ? want : res);
            n_groups++;
            if (res.caught) n_caught++;
        end
    endtask

    // sender holds off until every result is back and the last beat has left the scan
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (expected_verdicts.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [31:0] value);
        logic [31:0] stored;
        stored  = '0;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (addr == REG_HALF_WIDTH) begin
            half_width = value[HW_W-1:0];
            stored     = 32'(half_width);
        end else if (addr == REG_TRAP_COUNT) begin
            trap_count = value[CNT_W-1:0];
            stored     = 32'(trap_count);
        end
        n_settings++;
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== stored)
            flag_error($sformatf("MISMATCH reg 0x%0h readback: expected 0x%0h got 0x%0h",
                                 addr, stored, prdata));
        psel    <= 1'b0;
        penable <= 1'b0;
        // psel drops before the next transfer
        @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin : result_check
        t_verdict got;
        t_verdict want;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = '{m_axis_tdata[0], m_axis_tdata[6:1], m_axis_tdata[10:7]};
                n_results++;
                if (expected_verdicts.size() == 0) begin
                    flag_error(
                        $sformatf("MISMATCH result %0d unexpected: caught %0b trap %0d visit %0d",
                                  n_results, got.caught, got.trap, got.visit));
                end else begin
                    want = expected_verdicts.pop_front();
                    if (got.caught !== want.caught || got.trap !== want.trap ||
                        got.visit !== want.visit)
                        flag_error($sformatf(
                        "MISMATCH result %0d exp/act: caught %0b/%0b trap %0d/%0d visit %0d/%0d",
                            n_results, want.caught, got.caught, want.trap, got.trap,
                            want.visit, got.visit));
                end
                rx_wait = rx_steady ? 0 : $urandom_range(0, 9);
            end else if (rx_wait > 0) begin
                rx_wait--;
            end
            m_axis_tready <= (rx_wait == 0);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_verdicts.size());
            $display("tb_first_trap_box_match: errors");
            $finish;
        end
    end

    initial begin : stimulus
        t_plan_row       plan[$];
        t_verdict        none;
        int              hw;
        int              cnt;
        int              beats;
        int              pick;
        int              len;
        int              span;
        int              k;
        logic [FIELD_W-1:0] vx;
        logic [FIELD_W-1:0] vy;

        none = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // write every slot first so no scan ever reads an empty entry;
        // slots 2..4 and 6..62 end up on a row far from everything the table below visits
        tx_steady = 1'b1;
        for (int j = 0; j < TRAP_SLOTS_DEF; j++)
            send_beat(MODE_LOAD, SLOT_W'(j), FIELD_W'(j * 512 - 32768), 16'h7F00,
                      1'b0, 1'b0, none);
        tx_steady = 1'b0;

        plan.push_back(load_row(6'd0,  16'h0000, 16'h0000, 1'b1));  // tlast ignored on loads
        plan.push_back(load_row(6'd63, 16'h7FFF, 16'h7FFF, 1'b0));
        plan.push_back(load_row(6'd1,  16'h8000, 16'h8000, 1'b0));
        plan.push_back(caught_row(16'h0000, 16'h0000, 1'b1, 6'd0,  4'd0));
        plan.push_back(caught_row(16'h7FFF, 16'h7FFF, 1'b1, 6'd63, 4'd0));
        plan.push_back(caught_row(16'h8000, 16'h8000, 1'b1, 6'd1,  4'd0));
        plan.push_back(caught_row(16'h0100, 16'hFF00, 1'b1, 6'd0,  4'd0));  // both on the edge
        // third visit hits; the closing visit is skipped
        plan.push_back(visit_row(16'h4000, 16'h4000, 1'b0));
        plan.push_back(visit_row(16'h4000, 16'hC000, 1'b0));
        plan.push_back(visit_row(16'h0100, 16'h0000, 1'b0));
        plan.push_back(caught_row(16'h0000, 16'h0000, 1'b1, 6'd0, 4'd2));
        // load in the middle of a group keeps the group going
        plan.push_back(visit_row(16'h4000, 16'h4000, 1'b0));
        plan.push_back(load_row(6'd5, 16'h0000, 16'h0101, 1'b1));
        plan.push_back(caught_row(16'h0000, 16'h0101, 1'b1, 6'd5, 4'd1));
        plan.push_back(caught_row(16'h0101, 16'h0000, 1'b0, 6'd0, 4'd0));  // one LSB outside
        plan.push_back(cfg_row(REG_HALF_WIDTH, 32'd0));
        plan.push_back(caught_row(16'h0000, 16'h0000, 1'b1, 6'd0, 4'd0));
        plan.push_back(caught_row(16'h0000, 16'h0001, 1'b0, 6'd0, 4'd0));
        plan.push_back(cfg_row(REG_TRAP_COUNT, 32'd1));
        plan.push_back(cfg_row(REG_HALF_WIDTH, 32'd256));
        plan.push_back(caught_row(16'h7FFF, 16'h7FFF, 1'b0, 6'd0, 4'd0));  // only slot 0 scanned
        plan.push_back(cfg_row(REG_TRAP_COUNT, 32'd0));
        plan.push_back(caught_row(16'h0000, 16'h0000, 1'b0, 6'd0, 4'd0));
        plan.push_back(cfg_row(REG_TRAP_COUNT, 32'd127));
        plan.push_back(cfg_row(REG_HALF_WIDTH, 32'd32767));
        plan.push_back(caught_row(16'h8000, 16'h8000, 1'b1, 6'd1, 4'd0));
        plan.push_back(caught_row(16'h7FFF, 16'h8000, 1'b0, 6'd0, 4'd0));

        foreach (plan[i]) begin
            if (plan[i].is_cfg) begin
                drain();
                write_reg(plan[i].addr, plan[i].value);
            end else begin
                send_beat(plan[i].mode, plan[i].slot, plan[i].x, plan[i].y, plan[i].last,
                          plan[i].pinned, plan[i].want);
            end
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            drain();
            case (ph)
                0:       begin hw = 0;                         cnt = TRAP_SLOTS_DEF;        end
                1:       begin hw = 32767;                     cnt = 1;                     end
                2:       begin hw = $urandom_range(0, 600);    cnt = 127;                   end
                3:       begin hw = $urandom_range(1, 300);    cnt = 0;                     end
                default: begin hw = $urandom_range(0, 2000);   cnt = $urandom_range(1, 64); end
            endcase
            // junk in the upper bits must not reach the registers
            write_reg(REG_HALF_WIDTH, ($urandom() & 32'hFFFF_8000) | 32'(hw));
            write_reg(REG_TRAP_COUNT, ($urandom() & 32'hFFFF_FF80) | 32'(cnt));
            rx_steady = (ph % 3 == 2);
            span = (cnt == 0 || cnt > TRAP_SLOTS_DEF) ? TRAP_SLOTS_DEF : cnt;

            beats = 0;
            while (beats < PHASE_BEATS) begin
                pick = $urandom_range(0, 19);
                len  = (pick < 14) ? $urandom_range(1, 6) :
                       (pick < 18) ? $urandom_range(7, 16) : $urandom_range(17, 20);
                tx_steady = ($urandom_range(0, 5) == 0);
                for (int v = 0; v < len; v++) begin
                    if ($urandom_range(0, 9) == 0) begin
                        send_beat(MODE_LOAD, SLOT_W'($urandom_range(0, span - 1)),
                                  FIELD_W'($urandom), FIELD_W'($urandom),
                                  1'($urandom_range(0, 1)), 1'b0, none);
                        beats++;
                    end
                    // long groups stay off the traps until the position has saturated
                    if ((len <= 16 || v >= 16) && $urandom_range(0, 1) == 1) begin
                        k  = $urandom_range(0, span - 1);
                        vx = FIELD_W'(int'(trap_x[k]) + near_offset());
                        vy = FIELD_W'(int'(trap_y[k]) + near_offset());
                    end else begin
                        vx = FIELD_W'($urandom);
                        vy = FIELD_W'($urandom);
                    end
                    send_beat(MODE_VISIT, SLOT_W'($urandom), vx, vy, v == len - 1, 1'b0, none);
                    beats++;
                end
            end
        end
        tx_steady = 1'b0;
        drain();

        $display("covered %0d load beats, %0d visit beats, %0d groups (%0d caught)",
                 n_loads, n_visits, n_groups, n_caught);
        $display("%0d groups hit the top visit position; %0d register writes; %0d mismatches",
                 n_long, n_settings, errors);
        if (errors == 0) begin
            $display("tb_first_trap_box_match: clean");
        end else begin
            $display("tb_first_trap_box_match: errors");
        end
        $finish;
    end

endmodule
